[rtl/joystick_deadzone_command_mapper_assert.svh]
// ----------------------------------------------------------------------------
// Joystick command mapper assertion macros
// Shorthand for clocked checks that are disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DEADZONE_COMMAND_MAPPER_ASSERT_SVH
`define JOYSTICK_DEADZONE_COMMAND_MAPPER_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define JDCM_ASSERT_SAME(label, cause, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (result)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define JDCM_ASSERT_NEXT(label, cause, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (result)) \
        else $error(msg);

`endif

[rtl/jdcm_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick command mapper package
// Register indexes, reset values, output codes and text formatting helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package jdcm_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_THROTTLE_CENTRE   = 3'd0,
        REG_THROTTLE_TOP      = 3'd1,
        REG_THROTTLE_DEADZONE = 3'd2,
        REG_STEER_CENTRE      = 3'd3,
        REG_STEER_TOP         = 3'd4,
        REG_STEER_DEADZONE    = 3'd5
    } cfg_reg_t;

    // Register reset values, in ADC counts
    localparam int THROTTLE_CENTRE_RESET   = 2048;
    localparam int THROTTLE_TOP_RESET      = 4095;
    localparam int THROTTLE_DEADZONE_RESET = 248;
    localparam int STEER_CENTRE_RESET      = 2048;
    localparam int STEER_TOP_RESET         = 4095;
    localparam int STEER_DEADZONE_RESET    = 621;

    // Motion codes
    typedef enum logic [1:0] {
        MOTION_STOP     = 2'd0,
        MOTION_FORWARD  = 2'd1,
        MOTION_BACKWARD = 2'd2
    } motion_t;

    // Result value widths
    localparam int VALUE_BITS = 7;
    localparam int TEXT_BITS  = 32;
    localparam int QUOT_BITS  = 7;

    // Scaling and limits
    localparam logic [VALUE_BITS-1:0] SPEED_SCALE    = 7'd100;
    localparam logic [VALUE_BITS-1:0] SPEED_MAX      = 7'd99;
    localparam logic [VALUE_BITS-1:0] HEADING_SCALE  = 7'd20;
    localparam logic [VALUE_BITS-1:0] HEADING_CENTRE = 7'd50;
    localparam logic [VALUE_BITS-1:0] HEADING_MIN    = 7'd30;
    localparam logic [VALUE_BITS-1:0] HEADING_MAX    = 7'd70;

    // ASCII characters of the command words
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_ONE  = 8'h31;

    // Reciprocal of ten for values up to 99: tens = (v * 205) >> 11
    localparam int                DEC_PROD_BITS = 15;
    localparam logic [14:0]       DEC_RECIP     = 15'd205;
    localparam logic [VALUE_BITS-1:0] DEC_BASE  = 7'd10;

    // Tens digit of a value 0..99
    function automatic logic [3:0] dec_tens(input logic [VALUE_BITS-1:0] value);
        logic [DEC_PROD_BITS-1:0] prod;
        prod = DEC_PROD_BITS'(value) * DEC_RECIP;
        return prod[14:11];
    endfunction

    // Units digit of a value 0..99
    function automatic logic [3:0] dec_units(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] tens_part;
        tens_part = VALUE_BITS'(dec_tens(value)) * DEC_BASE;
        return 4'(value - tens_part);
    endfunction

    // '0', motion digit, speed tens, speed units
    function automatic logic [TEXT_BITS-1:0] motion_word(
        input motion_t                 motion,
        input logic [VALUE_BITS-1:0]   speed
    );
        return {ASCII_ZERO,
                ASCII_ZERO + 8'(motion),
                ASCII_ZERO + 8'(dec_tens(speed)),
                ASCII_ZERO + 8'(dec_units(speed))};
    endfunction

    // '1', heading tens, heading units, '0'
    function automatic logic [TEXT_BITS-1:0] heading_word(
        input logic [VALUE_BITS-1:0] heading
    );
        return {ASCII_ONE,
                ASCII_ZERO + 8'(dec_tens(heading)),
                ASCII_ZERO + 8'(dec_units(heading)),
                ASCII_ZERO};
    endfunction

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[rtl/jdcm_if.sv]
// ----------------------------------------------------------------------------
// Joystick command mapper channels
// Valid/ready channels for samples, configuration writes and commands.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample pair channel
interface jdcm_sample_if #(parameter int SAMPLE_BITS = 12);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] throttle_sample;
    logic [SAMPLE_BITS-1:0] steer_sample;

    modport source (output valid, output throttle_sample, output steer_sample, input ready);
    modport sink   (input valid, input throttle_sample, input steer_sample, output ready);
endinterface

// Configuration write channel
interface jdcm_cfg_if #(parameter int SAMPLE_BITS = 12);
    logic                              valid;
    logic                              ready;
    logic [jdcm_pkg::CFG_INDEX_BITS-1:0] index;
    logic [SAMPLE_BITS-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// Command result channel
interface jdcm_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          motion;
    logic [jdcm_pkg::VALUE_BITS-1:0]     speed_percent;
    logic [jdcm_pkg::VALUE_BITS-1:0]     heading;
    logic [jdcm_pkg::TEXT_BITS-1:0]      motion_text;
    logic [jdcm_pkg::TEXT_BITS-1:0]      heading_text;

    modport source (output valid, output motion, output speed_percent, output heading,
                    output motion_text, output heading_text, input ready);
    modport sink   (input valid, input motion, input speed_percent, input heading,
                    input motion_text, input heading_text, output ready);
endinterface

`default_nettype wire

[rtl/jdcm_front.sv]
// ----------------------------------------------------------------------------
// Joystick command mapper front end
// Holds the calibration registers and classifies each sample pair against
// centre and deadzone, producing offsets and spans for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcm_front #(
    parameter  int SAMPLE_BITS = 12,
    localparam int ENTRY_BITS  = 4 * SAMPLE_BITS + 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    jdcm_cfg_if.sink                   cfg,
    jdcm_sample_if.sink                samples,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output logic [ENTRY_BITS-1:0]      push_data
);

    typedef struct packed {
        jdcm_pkg::motion_t      motion;
        logic                   t_act;
        logic                   t_span_ok;
        logic [SAMPLE_BITS-1:0] t_off;
        logic [SAMPLE_BITS-1:0] t_span;
        logic                   s_act;
        logic                   s_left;
        logic                   s_span_ok;
        logic [SAMPLE_BITS-1:0] s_off;
        logic [SAMPLE_BITS-1:0] s_span;
    } entry_t;

    logic [SAMPLE_BITS-1:0] throttle_centre_reg;
    logic [SAMPLE_BITS-1:0] throttle_top_reg;
    logic [SAMPLE_BITS-1:0] throttle_deadzone_reg;
    logic [SAMPLE_BITS-1:0] steer_centre_reg;
    logic [SAMPLE_BITS-1:0] steer_top_reg;
    logic [SAMPLE_BITS-1:0] steer_deadzone_reg;

    logic                   t_ge;
    logic                   s_ge;
    logic [SAMPLE_BITS-1:0] t_off;
    logic [SAMPLE_BITS-1:0] s_off;
    entry_t                 entry_next;
    entry_t                 entry_reg;
    logic                   front_valid_reg;
    logic                   advance;

    // Accept every configuration transfer; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_centre_reg   <= SAMPLE_BITS'(jdcm_pkg::THROTTLE_CENTRE_RESET);
            throttle_top_reg      <= SAMPLE_BITS'(jdcm_pkg::THROTTLE_TOP_RESET);
            throttle_deadzone_reg <= SAMPLE_BITS'(jdcm_pkg::THROTTLE_DEADZONE_RESET);
            steer_centre_reg      <= SAMPLE_BITS'(jdcm_pkg::STEER_CENTRE_RESET);
            steer_top_reg         <= SAMPLE_BITS'(jdcm_pkg::STEER_TOP_RESET);
            steer_deadzone_reg    <= SAMPLE_BITS'(jdcm_pkg::STEER_DEADZONE_RESET);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                jdcm_pkg::REG_THROTTLE_CENTRE:   throttle_centre_reg   <= cfg.data;
                jdcm_pkg::REG_THROTTLE_TOP:      throttle_top_reg      <= cfg.data;
                jdcm_pkg::REG_THROTTLE_DEADZONE: throttle_deadzone_reg <= cfg.data;
                jdcm_pkg::REG_STEER_CENTRE:      steer_centre_reg      <= cfg.data;
                jdcm_pkg::REG_STEER_TOP:         steer_top_reg         <= cfg.data;
                jdcm_pkg::REG_STEER_DEADZONE:    steer_deadzone_reg    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Fold each axis about its centre
    assign t_ge  = samples.throttle_sample >= throttle_centre_reg;
    assign s_ge  = samples.steer_sample >= steer_centre_reg;
    assign t_off = t_ge ? samples.throttle_sample - throttle_centre_reg
                        : throttle_centre_reg - samples.throttle_sample;
    assign s_off = s_ge ? samples.steer_sample - steer_centre_reg
                        : steer_centre_reg - samples.steer_sample;

    // Classify against the deadzone and work out the spans
    always_comb
    begin
        entry_next.t_act     = t_off > throttle_deadzone_reg;
        entry_next.t_off     = t_off;
        entry_next.t_span_ok = throttle_top_reg > throttle_centre_reg;
        entry_next.t_span    = throttle_top_reg - throttle_centre_reg;
        if (!entry_next.t_act)
            entry_next.motion = jdcm_pkg::MOTION_STOP;
        else if (t_ge)
            entry_next.motion = jdcm_pkg::MOTION_BACKWARD;
        else
            entry_next.motion = jdcm_pkg::MOTION_FORWARD;
        entry_next.s_act     = s_off > steer_deadzone_reg;
        entry_next.s_left    = !s_ge;
        entry_next.s_off     = s_off;
        entry_next.s_span_ok = steer_top_reg > steer_centre_reg;
        entry_next.s_span    = steer_top_reg - steer_centre_reg;
    end

    // Advance the front register whenever the queue can take its contents
    assign advance       = !front_valid_reg || push_ready;
    assign samples.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (advance)
            front_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            entry_reg <= entry_next;
    end

    assign push_valid = front_valid_reg;
    assign push_data  = entry_reg;

endmodule

`default_nettype wire

[rtl/jdcm_queue.sv]
// ----------------------------------------------------------------------------
// Joystick command mapper queue
// Short first-in first-out buffer that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcm_queue #(
    parameter int WIDTH = 55
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int DEPTH      = jdcm_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]      slot_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  push;
    logic                  pop;

    assign push_ready = count_reg != COUNT_BITS'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + COUNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - COUNT_BITS'(1);
    end

    // Advance pointers with wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_BITS'(1);
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[rtl/jdcm_back.sv]
// ----------------------------------------------------------------------------
// Joystick command mapper back end
// Scales the classified offsets by their spans in a bit-per-stage divider
// pipeline, saturates, and formats the command words into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jdcm_back #(
    parameter  int SAMPLE_BITS = 12,
    localparam int ENTRY_BITS  = 4 * SAMPLE_BITS + 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire logic [ENTRY_BITS-1:0] pop_data,
    jdcm_cmd_if.source                 commands
);

    localparam int QB        = jdcm_pkg::QUOT_BITS;
    localparam int VB        = jdcm_pkg::VALUE_BITS;
    localparam int NUM_BITS  = SAMPLE_BITS + QB;
    localparam int DIV_STEPS = QB + 1;

    typedef struct packed {
        jdcm_pkg::motion_t      motion;
        logic                   t_act;
        logic                   t_span_ok;
        logic [SAMPLE_BITS-1:0] t_off;
        logic [SAMPLE_BITS-1:0] t_span;
        logic                   s_act;
        logic                   s_left;
        logic                   s_span_ok;
        logic [SAMPLE_BITS-1:0] s_off;
        logic [SAMPLE_BITS-1:0] s_span;
    } entry_t;

    typedef struct packed {
        jdcm_pkg::motion_t      motion;
        logic                   t_act;
        logic                   t_sat;
        logic [NUM_BITS-1:0]    t_rem;
        logic [SAMPLE_BITS-1:0] t_den;
        logic [QB-1:0]          t_q;
        logic                   s_act;
        logic                   s_left;
        logic                   s_sat;
        logic [NUM_BITS-1:0]    s_rem;
        logic [SAMPLE_BITS-1:0] s_den;
        logic [QB-1:0]          s_q;
    } pipe_t;

    // Flag a quotient of 2^QB or more on both axes
    function automatic pipe_t sat_check(input pipe_t p);
        pipe_t r;
        r = p;
        if (p.t_rem >= (NUM_BITS'(p.t_den) << QB))
            r.t_sat = 1'b1;
        if (p.s_rem >= (NUM_BITS'(p.s_den) << QB))
            r.s_sat = 1'b1;
        return r;
    endfunction

    // One restoring division step on both axes
    function automatic pipe_t div_bit(input pipe_t p, input logic [$clog2(QB)-1:0] pos);
        pipe_t               r;
        logic [NUM_BITS-1:0] t_sub;
        logic [NUM_BITS-1:0] s_sub;
        r     = p;
        t_sub = NUM_BITS'(p.t_den) << pos;
        s_sub = NUM_BITS'(p.s_den) << pos;
        if (p.t_rem >= t_sub)
        begin
            r.t_rem    = p.t_rem - t_sub;
            r.t_q[pos] = 1'b1;
        end
        if (p.s_rem >= s_sub)
        begin
            r.s_rem    = p.s_rem - s_sub;
            r.s_q[pos] = 1'b1;
        end
        return r;
    endfunction

    entry_t              entry;
    logic                en;
    logic [DIV_STEPS:0]  valid_reg;
    pipe_t               pipe_reg  [DIV_STEPS+1];
    pipe_t               pipe_next [DIV_STEPS+1];
    pipe_t               last;
    logic [NUM_BITS-1:0] s_bias;

    logic [VB-1:0]                   speed_next;
    logic [VB-1:0]                   heading_next;
    logic                            out_valid_reg;
    jdcm_pkg::motion_t               motion_reg;
    logic [VB-1:0]                   speed_reg;
    logic [VB-1:0]                   heading_reg;
    logic [jdcm_pkg::TEXT_BITS-1:0]  motion_text_reg;
    logic [jdcm_pkg::TEXT_BITS-1:0]  heading_text_reg;

    // Move the whole pipeline when the output register is free or drained
    assign en        = !out_valid_reg || commands.ready;
    assign pop_ready = en;
    assign entry     = entry_t'(pop_data);

    // Form the numerators; a left offset is rounded up by adding span - 1
    assign s_bias = entry.s_left ? NUM_BITS'(entry.s_span) - NUM_BITS'(1) : '0;

    always_comb
    begin
        pipe_next[0].motion = entry.motion;
        pipe_next[0].t_act  = entry.t_act;
        pipe_next[0].t_sat  = !entry.t_span_ok;
        pipe_next[0].t_rem  = NUM_BITS'(entry.t_off) * NUM_BITS'(jdcm_pkg::SPEED_SCALE);
        pipe_next[0].t_den  = entry.t_span;
        pipe_next[0].t_q    = '0;
        pipe_next[0].s_act  = entry.s_act;
        pipe_next[0].s_left = entry.s_left;
        pipe_next[0].s_sat  = !entry.s_span_ok;
        pipe_next[0].s_rem  = NUM_BITS'(entry.s_off) * NUM_BITS'(jdcm_pkg::HEADING_SCALE)
                              + s_bias;
        pipe_next[0].s_den  = entry.s_span;
        pipe_next[0].s_q    = '0;
    end

    // Divider stages: saturation check first, then one quotient bit each
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        if (i == 0)
        begin : g_sat
            always_comb pipe_next[i+1] = sat_check(pipe_reg[i]);
        end
        else
        begin : g_bit
            localparam int POS = QB - i;
            always_comb pipe_next[i+1] = div_bit(pipe_reg[i], ($clog2(QB))'(POS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DIV_STEPS-1:0], pop_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pipe_reg <= pipe_next;
    end

    // Saturate the quotients into speed and heading
    assign last = pipe_reg[DIV_STEPS];

    always_comb
    begin
        if (!last.t_act)
            speed_next = '0;
        else if (last.t_sat || last.t_q > jdcm_pkg::SPEED_MAX)
            speed_next = jdcm_pkg::SPEED_MAX;
        else
            speed_next = VB'(last.t_q);

        if (!last.s_act)
            heading_next = jdcm_pkg::HEADING_CENTRE;
        else if (last.s_sat || VB'(last.s_q) >= jdcm_pkg::HEADING_SCALE)
            heading_next = last.s_left ? jdcm_pkg::HEADING_MIN : jdcm_pkg::HEADING_MAX;
        else if (last.s_left)
            heading_next = jdcm_pkg::HEADING_CENTRE - VB'(last.s_q);
        else
            heading_next = jdcm_pkg::HEADING_CENTRE + VB'(last.s_q);
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            motion_reg       <= last.motion;
            speed_reg        <= speed_next;
            heading_reg      <= heading_next;
            motion_text_reg  <= jdcm_pkg::motion_word(last.motion, speed_next);
            heading_text_reg <= jdcm_pkg::heading_word(heading_next);
        end
    end

    assign commands.valid         = out_valid_reg;
    assign commands.motion        = motion_reg;
    assign commands.speed_percent = speed_reg;
    assign commands.heading       = heading_reg;
    assign commands.motion_text   = motion_text_reg;
    assign commands.heading_text  = heading_text_reg;

endmodule

`default_nettype wire

[rtl/joystick_deadzone_command_mapper.sv]
// ----------------------------------------------------------------------------
// Joystick deadzone command mapper
// Turns throttle and steering ADC sample pairs into motion, speed and
// heading commands, as numbers and as packed ASCII command words.
// ----------------------------------------------------------------------------
// Usage:
//   samples  - sink of throttle/steering sample pairs (valid/ready).
//   cfg      - register writes: index 0..5 selects centre, top and deadzone
//              of throttle then steering; other indexes are dropped. Always
//              ready; write only while no sample is in flight.
//   commands - one result per sample pair, in order (valid/ready).
// A sample transfer loads the front register; the entry then passes in order
// through the queue, the numerator stage, a saturation stage, seven divider
// stages (one quotient bit each) and the output register, where its result
// shows valid.
// Throughput is one sample pair per cycle while the receiver does not stall.
// Reset empties the pipeline and queue and loads the calibration defaults.
// When the receiver stalls, the result holds and the back end freezes; the
// two-entry queue and front register then fill before samples is not ready.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_deadzone_command_mapper #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    jdcm_cfg_if.sink    cfg,
    jdcm_sample_if.sink samples,
    jdcm_cmd_if.source  commands
);

    localparam int ENTRY_BITS = 4 * SAMPLE_BITS + 7;

    logic                  push_valid;
    logic                  push_ready;
    logic [ENTRY_BITS-1:0] push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [ENTRY_BITS-1:0] pop_data;

    // Classify samples
    jdcm_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .samples    (samples),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple front and back
    jdcm_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Scale and format
    jdcm_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .commands  (commands)
    );

endmodule

`default_nettype wire

[rtl/jdcm_checker.sv]
// ----------------------------------------------------------------------------
// Joystick command mapper checker
// Port-level checks on the command channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joystick_deadzone_command_mapper_assert.svh"

module jdcm_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               cmd_valid,
    input wire logic                               cmd_ready,
    input wire logic [1:0]                         motion,
    input wire logic [jdcm_pkg::VALUE_BITS-1:0]    speed_percent,
    input wire logic [jdcm_pkg::VALUE_BITS-1:0]    heading,
    input wire logic [jdcm_pkg::TEXT_BITS-1:0]     motion_text,
    input wire logic [jdcm_pkg::TEXT_BITS-1:0]     heading_text
);

    // A stalled result must hold its command words
    `JDCM_ASSERT_NEXT(a_hold_stalled, cmd_valid && !cmd_ready, cmd_valid && $stable(motion_text) && $stable(heading_text), "command changed while stalled")

    // Stop carries no speed and a valid result stays within its ranges
    `JDCM_ASSERT_SAME(a_stop_no_speed, cmd_valid && motion == jdcm_pkg::MOTION_STOP, speed_percent == '0, "stop with non-zero speed")

    `JDCM_ASSERT_SAME(a_ranges, cmd_valid, speed_percent <= jdcm_pkg::SPEED_MAX && heading >= jdcm_pkg::HEADING_MIN && heading <= jdcm_pkg::HEADING_MAX, "speed or heading out of range")

    // Command words frame the numbers with their fixed characters
    `JDCM_ASSERT_SAME(a_text_frame, cmd_valid, motion_text[31:24] == jdcm_pkg::ASCII_ZERO && motion_text[23:16] == jdcm_pkg::ASCII_ZERO + 8'(motion) && heading_text[31:24] == jdcm_pkg::ASCII_ONE && heading_text[7:0] == jdcm_pkg::ASCII_ZERO, "command word framing wrong")

endmodule

bind joystick_deadzone_command_mapper jdcm_checker u_jdcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (commands.valid),
    .cmd_ready     (commands.ready),
    .motion        (commands.motion),
    .speed_percent (commands.speed_percent),
    .heading       (commands.heading),
    .motion_text   (commands.motion_text),
    .heading_text  (commands.heading_text)
);

`default_nettype wire

[verif/joystick_deadzone_command_mapper_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joystick deadzone command mapper testbench
// Drives sample pairs against a series of calibrations, directed first and
// then random, with random idle bursts on both channels. Each command is
// compared field by field with an in-order queue of predicted commands.
// ----------------------------------------------------------------------------

module joystick_deadzone_command_mapper_tb;

    import jdcm_pkg::*;

    localparam int SAMPLE_BITS   = 12;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int PIPE_LATENCY  = 12;
    localparam int RANDOM_PHASES = 15;
    localparam int CALM_PHASES   = 3;

    // Indexes past the last register; writes to them must be dropped
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        motion_t                 motion;
        logic [VALUE_BITS-1:0]   speed;
        logic [VALUE_BITS-1:0]   heading;
        logic [TEXT_BITS-1:0]    mtext;
        logic [TEXT_BITS-1:0]    htext;
    } command_t;

    typedef struct {
        bit                          is_write;
        logic [CFG_INDEX_BITS-1:0]   idx;
        logic [SAMPLE_BITS-1:0]      a;
        logic [SAMPLE_BITS-1:0]      b;
        bit                          typed;
        command_t                    want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    jdcm_cfg_if    #(.SAMPLE_BITS(SAMPLE_BITS)) cfg_ch ();
    jdcm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_ch ();
    jdcm_cmd_if                                 cmd_ch ();

    // Calibration as the block should hold it
    logic [SAMPLE_BITS-1:0] cal [0:5];

    command_t  pending_cmds [$];
    plan_row_t plan [$];
    int        errors     = 0;
    int        stall_left = 0;
    bit        src_idle   = 1'b0;
    bit        sink_idle  = 1'b0;

    joystick_deadzone_command_mapper #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .samples  (smp_ch),
        .commands (cmd_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("joystick_deadzone_command_mapper: mismatch");
        $finish;
    end

    // Work out the command for one sample pair under the current calibration
    function automatic command_t map_pair(input logic [SAMPLE_BITS-1:0] thr,
                                          input logic [SAMPLE_BITS-1:0] str);
        command_t c;
        int tc, tdz, sc, sdz, t_span, s_span, off, q, sp, hd;
        tc     = int'(cal[REG_THROTTLE_CENTRE]);
        tdz    = int'(cal[REG_THROTTLE_DEADZONE]);
        sc     = int'(cal[REG_STEER_CENTRE]);
        sdz    = int'(cal[REG_STEER_DEADZONE]);
        t_span = int'(cal[REG_THROTTLE_TOP]) - tc;
        s_span = int'(cal[REG_STEER_TOP]) - sc;
        c      = '0;
        c.motion = MOTION_STOP;
        sp = 0;
        hd = int'(HEADING_CENTRE);

        // Throttle: at or above centre is backward, below is forward
        off = (int'(thr) >= tc) ? int'(thr) - tc : tc - int'(thr);
        if (off > tdz)
        begin
            c.motion = (int'(thr) >= tc) ? MOTION_BACKWARD : MOTION_FORWARD;
            q  = (t_span <= 0) ? int'(SPEED_MAX) : (off * int'(SPEED_SCALE)) / t_span;
            sp = (q > int'(SPEED_MAX)) ? int'(SPEED_MAX) : q;
        end

        // Steering: truncate to the right, round away from centre to the left
        if (int'(str) >= sc)
        begin
            off = int'(str) - sc;
            if (off > sdz)
            begin
                q  = (s_span <= 0) ? int'(HEADING_SCALE) : (off * int'(HEADING_SCALE)) / s_span;
                hd = (q >= int'(HEADING_SCALE)) ? int'(HEADING_MAX) : int'(HEADING_CENTRE) + q;
            end
        end
        else
        begin
            off = sc - int'(str);
            if (off > sdz)
            begin
                q  = (s_span <= 0) ? int'(HEADING_SCALE)
                                   : (off * int'(HEADING_SCALE) + s_span - 1) / s_span;
                hd = (q >= int'(HEADING_SCALE)) ? int'(HEADING_MIN) : int'(HEADING_CENTRE) - q;
            end
        end

        c.speed   = VALUE_BITS'(sp);
        c.heading = VALUE_BITS'(hd);
        c.mtext   = {ASCII_ZERO, ASCII_ZERO + 8'(c.motion),
                     ASCII_ZERO + 8'(sp / 10), ASCII_ZERO + 8'(sp % 10)};
        c.htext   = {ASCII_ONE, ASCII_ZERO + 8'(hd / 10),
                     ASCII_ZERO + 8'(hd % 10), ASCII_ZERO};
        return c;
    endfunction

    // Pick a sample value, biased towards the deadzone edges of one axis
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int centre, input int dz);
        int v, mag;
        bit up;
        up = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, SAMPLE_MAX);
            4, 5, 6, 7:
            begin
                mag = dz + int'($urandom_range(0, 1200));
                v   = up ? centre + mag : centre - mag;
            end
            8:
            begin
                mag = dz + int'($urandom_range(0, 1));
                v   = up ? centre + mag : centre - mag;
            end
            default: v = up ? SAMPLE_MAX : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_BITS'(v);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return SAMPLE_BITS'(1);
            2:       return SAMPLE_BITS'(SAMPLE_MAX - 1);
            default: return SAMPLE_BITS'(SAMPLE_MAX);
        endcase
    endfunction

    // Stimulus table builders
    function automatic void add_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input int value);
        plan_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.idx      = idx;
        r.a        = SAMPLE_BITS'(value);
        plan.push_back(r);
    endfunction

    function automatic void add_pair(input int thr, input int str);
        plan_row_t r;
        r   = '{default: '0};
        r.a = SAMPLE_BITS'(thr);
        r.b = SAMPLE_BITS'(str);
        plan.push_back(r);
    endfunction

    function automatic void add_known(input int thr, input int str, input motion_t m,
                                      input int sp, input int hd,
                                      input logic [TEXT_BITS-1:0] mt,
                                      input logic [TEXT_BITS-1:0] ht);
        plan_row_t r;
        r              = '{default: '0};
        r.a            = SAMPLE_BITS'(thr);
        r.b            = SAMPLE_BITS'(str);
        r.typed        = 1'b1;
        r.want.motion  = m;
        r.want.speed   = VALUE_BITS'(sp);
        r.want.heading = VALUE_BITS'(hd);
        r.want.mtext   = mt;
        r.want.htext   = ht;
        plan.push_back(r);
    endfunction

    // Offer one sample pair, optionally after an idle burst, and queue its command
    task automatic send_pair(input logic [SAMPLE_BITS-1:0] thr,
                             input logic [SAMPLE_BITS-1:0] str,
                             input bit typed, input command_t want);
        cfg_ch.valid <= 1'b0;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            smp_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        smp_ch.valid           <= 1'b1;
        smp_ch.throttle_sample <= thr;
        smp_ch.steer_sample    <= str;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        pending_cmds.push_back(typed ? want : map_pair(thr, str));
    endtask

    // Drain the pipeline, then write one register
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] value);
        smp_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx <= REG_STEER_DEADZONE)
            cal[idx] = value;
    endtask

    task automatic set_calibration(input int tc, input int tt, input int tdz,
                                   input int sc, input int st, input int sdz);
        write_reg(REG_THROTTLE_CENTRE,   SAMPLE_BITS'(tc));
        write_reg(REG_THROTTLE_TOP,      SAMPLE_BITS'(tt));
        write_reg(REG_THROTTLE_DEADZONE, SAMPLE_BITS'(tdz));
        write_reg(REG_STEER_CENTRE,      SAMPLE_BITS'(sc));
        write_reg(REG_STEER_TOP,         SAMPLE_BITS'(st));
        write_reg(REG_STEER_DEADZONE,    SAMPLE_BITS'(sdz));
    endtask

    task automatic check_field(input string what, input logic [TEXT_BITS-1:0] want,
                               input logic [TEXT_BITS-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s: expected 0x%0h, actual 0x%0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Command sink: hold ready low in random bursts while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            cmd_ch.ready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 6);
            cmd_ch.ready <= 1'b0;
        end
        else
            cmd_ch.ready <= 1'b1;
    end

    // Compare each command transfer with the oldest prediction
    always @(posedge clk)
    begin
        command_t want;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            if (pending_cmds.size() == 0)
            begin
                $display("%0t command: expected none, actual motion %0d speed %0d heading %0d",
                         $time, cmd_ch.motion, cmd_ch.speed_percent, cmd_ch.heading);
                errors++;
            end
            else
            begin
                want = pending_cmds.pop_front();
                check_field("motion",        TEXT_BITS'(want.motion),  TEXT_BITS'(cmd_ch.motion));
                check_field("speed_percent", TEXT_BITS'(want.speed),
                            TEXT_BITS'(cmd_ch.speed_percent));
                check_field("heading",       TEXT_BITS'(want.heading), TEXT_BITS'(cmd_ch.heading));
                check_field("motion_text",   want.mtext, cmd_ch.motion_text);
                check_field("heading_text",  want.htext, cmd_ch.heading_text);
            end
        end
    end

    // Main sequence
    initial
    begin
        int        tc, tt, tdz, sc, st, sdz, n;
        command_t  none;

        none                   = '0;
        rst_n                  = 1'b0;
        smp_ch.valid           = 1'b0;
        smp_ch.throttle_sample = '0;
        smp_ch.steer_sample    = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        cmd_ch.ready           = 1'b0;

        cal[REG_THROTTLE_CENTRE]   = SAMPLE_BITS'(THROTTLE_CENTRE_RESET);
        cal[REG_THROTTLE_TOP]      = SAMPLE_BITS'(THROTTLE_TOP_RESET);
        cal[REG_THROTTLE_DEADZONE] = SAMPLE_BITS'(THROTTLE_DEADZONE_RESET);
        cal[REG_STEER_CENTRE]      = SAMPLE_BITS'(STEER_CENTRE_RESET);
        cal[REG_STEER_TOP]         = SAMPLE_BITS'(STEER_TOP_RESET);
        cal[REG_STEER_DEADZONE]    = SAMPLE_BITS'(STEER_DEADZONE_RESET);

        // Reset calibration: centre, full deflection, deadzone edges
        add_known(2048, 2048, MOTION_STOP,     0,  50, 32'h30303030, 32'h31353030);
        add_known(4095, 4095, MOTION_BACKWARD, 99, 70, 32'h30323939, 32'h31373030);
        add_known(0,    0,    MOTION_FORWARD,  99, 30, 32'h30313939, 32'h31333030);
        add_known(2296, 2669, MOTION_STOP,     0,  50, 32'h30303030, 32'h31353030);
        add_known(1800, 1427, MOTION_STOP,     0,  50, 32'h30303030, 32'h31353030);
        add_pair(2297, 2670);
        add_pair(1799, 1426);
        add_pair(3000, 1000);
        add_pair(3072, 3500);
        // Writes past the last register leave the calibration alone
        add_write(REG_SPARE_A, 0);
        add_write(REG_SPARE_B, 4095);
        add_pair(4095, 0);
        // Zero span saturates both axes
        add_write(REG_THROTTLE_TOP, 2048);
        add_write(REG_STEER_TOP, 2048);
        add_known(4095, 4095, MOTION_BACKWARD, 99, 70, 32'h30323939, 32'h31373030);
        add_known(0,    0,    MOTION_FORWARD,  99, 30, 32'h30313939, 32'h31333030);
        // Negative span with no deadzone
        add_write(REG_THROTTLE_CENTRE, 4095);
        add_write(REG_THROTTLE_TOP, 0);
        add_write(REG_THROTTLE_DEADZONE, 0);
        add_write(REG_STEER_CENTRE, 4095);
        add_write(REG_STEER_TOP, 0);
        add_write(REG_STEER_DEADZONE, 0);
        add_known(0,    0,    MOTION_FORWARD,  99, 30, 32'h30313939, 32'h31333030);
        add_known(4095, 4095, MOTION_STOP,     0,  50, 32'h30303030, 32'h31353030);
        // Deadzone covering the whole range
        add_write(REG_THROTTLE_CENTRE, 0);
        add_write(REG_THROTTLE_TOP, 4095);
        add_write(REG_THROTTLE_DEADZONE, 4095);
        add_write(REG_STEER_CENTRE, 0);
        add_write(REG_STEER_TOP, 4095);
        add_write(REG_STEER_DEADZONE, 4095);
        add_known(4095, 4095, MOTION_STOP,     0,  50, 32'h30303030, 32'h31353030);
        add_known(0,    0,    MOTION_STOP,     0,  50, 32'h30303030, 32'h31353030);
        // Zero deadzone at the bottom of the range
        add_write(REG_THROTTLE_DEADZONE, 0);
        add_write(REG_STEER_DEADZONE, 0);
        add_pair(1, 1);
        add_pair(4095, 4095);
        add_pair(2000, 205);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_reg(plan[i].idx, plan[i].a);
            else
                send_pair(plan[i].a, plan[i].b, plan[i].typed, plan[i].want);
        end

        // Random phases, each under a fresh calibration
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                tc = THROTTLE_CENTRE_RESET;  tt = THROTTLE_TOP_RESET;
                tdz = THROTTLE_DEADZONE_RESET;
                sc = STEER_CENTRE_RESET;     st = STEER_TOP_RESET;
                sdz = STEER_DEADZONE_RESET;
            end
            else if (phase % 5 == 3)
            begin
                tc = pick_extreme();  tt = pick_extreme();  tdz = pick_extreme();
                sc = pick_extreme();  st = pick_extreme();  sdz = pick_extreme();
            end
            else if (phase % 5 == 4)
            begin
                tc = $urandom_range(0, SAMPLE_MAX);  tt = $urandom_range(0, SAMPLE_MAX);
                tdz = $urandom_range(0, SAMPLE_MAX);
                sc = $urandom_range(0, SAMPLE_MAX);  st = $urandom_range(0, SAMPLE_MAX);
                sdz = $urandom_range(0, SAMPLE_MAX);
            end
            else
            begin
                tc  = $urandom_range(512, 3584);
                tt  = tc + int'($urandom_range(1, SAMPLE_MAX - tc));
                tdz = $urandom_range(0, 400);
                sc  = $urandom_range(512, 3584);
                st  = sc + int'($urandom_range(1, SAMPLE_MAX - sc));
                sdz = $urandom_range(0, 400);
            end
            set_calibration(tc, tt, tdz, sc, st, sdz);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)));

            // No idling in the closing phases
            src_idle  = (phase < RANDOM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);
            sink_idle = (phase < RANDOM_PHASES - CALM_PHASES) && ($urandom_range(0, 3) != 0);

            n = $urandom_range(85, 105);
            repeat (n)
                send_pair(pick_sample(tc, tdz), pick_sample(sc, sdz), 1'b0, none);
        end

        // Wait for the last commands, then allow for stragglers
        smp_ch.valid <= 1'b0;
        cfg_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        if (errors == 0)
            $display("joystick_deadzone_command_mapper: match");
        else
            $display("joystick_deadzone_command_mapper: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/jdcm_pkg.sv
rtl/jdcm_if.sv
rtl/jdcm_front.sv
rtl/jdcm_queue.sv
rtl/jdcm_back.sv
rtl/joystick_deadzone_command_mapper.sv
rtl/jdcm_checker.sv
verif/joystick_deadzone_command_mapper_tb.sv
